### design/led_matrix_cascade_refresh_macros.svh
// Assertion macros shared by the checker files of the LED matrix cascade driver.
`ifndef LED_MATRIX_CASCADE_REFRESH_MACROS_SVH
`define LED_MATRIX_CASCADE_REFRESH_MACROS_SVH

// Same-cycle implication: when cond holds, expr must hold in that cycle.
`define LMCR_ASSERT_NOW(label, clk, dis, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication: when cond holds, expr must hold in the next cycle.
`define LMCR_ASSERT_NEXT(label, clk, dis, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (cond) |=> (expr)) \
    else $error(msg);

`endif

### design/lmcr_pkg.sv
// Types and constants of the cascaded LED matrix refresh driver.
package lmcr_pkg;

  // Command codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_INIT    = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_INTENSITY = 2'd0;
  localparam logic [1:0] CFG_SCAN      = 2'd1;
  localparam logic [1:0] CFG_DECODE    = 2'd2;

  // Driver chip register addresses
  localparam logic [7:0] REG_DECODE    = 8'h09;
  localparam logic [7:0] REG_INTENSITY = 8'h0A;
  localparam logic [7:0] REG_SCAN      = 8'h0B;
  localparam logic [7:0] REG_SHUTDOWN  = 8'h0C;
  localparam logic [7:0] REG_TEST      = 8'h0F;

  localparam logic [7:0] NORMAL_OP_DATA = 8'd1;
  localparam logic [7:0] TEST_OFF_DATA  = 8'd0;

  // Init sequence group numbers
  localparam logic [2:0] GRP_DECODE    = 3'd0;
  localparam logic [2:0] GRP_INTENSITY = 3'd1;
  localparam logic [2:0] GRP_SCAN      = 3'd2;
  localparam logic [2:0] GRP_TEST      = 3'd3;
  localparam logic [2:0] GRP_SHUTDOWN  = 3'd4;
  localparam logic [2:0] INIT_LAST_GRP = GRP_SHUTDOWN;

  localparam int FRAME_DEPTH = 32;
  localparam int GRP_W       = 3;   // up to 8 groups
  localparam int CHIP_W      = 3;   // up to 8 chips
  localparam int COUNT_W     = 5;   // word count within one command
  localparam logic [COUNT_W-1:0] MAX_WORD_IDX = 5'd31;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] word_out;
    logic [1:0]  chain_slot;
    logic        latch_after;
    logic        last_word;
  } out_item_t;

  // Register address of one init group
  function automatic logic [7:0] init_addr(input logic [GRP_W-1:0] grp);
    logic [7:0] addr;
    case (grp)
      GRP_DECODE:    addr = REG_DECODE;
      GRP_INTENSITY: addr = REG_INTENSITY;
      GRP_SCAN:      addr = REG_SCAN;
      GRP_TEST:      addr = REG_TEST;
      GRP_SHUTDOWN:  addr = REG_SHUTDOWN;
      default:       addr = REG_SHUTDOWN;
    endcase
    return addr;
  endfunction

endpackage

### design/led_matrix_cascade_refresh.sv
// Top level of the cascaded LED matrix refresh driver.
//
// The block drives a chain of CHAIN_LENGTH LED driver chips with DIGIT_COUNT
// digits each, at word level: every result item is one 16-bit word (register
// address high byte, data low byte) for a downstream shifter, with its slot in
// the load group, a latch flag after the last chip of each group and a flag
// on the final word of the command. A 32-byte frame store, cleared at reset,
// holds one segment byte per chip and digit at chip*8 + digit. Commands:
// write one frame byte (no result; indexes beyond the chain are
// dropped), init (five broadcast groups: decode mode, intensity, scan limit,
// test off, shutdown off) and refresh (DIGIT_COUNT groups, one word per chip).
// Opcode 3 is dropped. A command never gives more than 32 words; a capped
// command ends on the 32nd word, which carries the last-word flag.
// A command is taken in the idle state; a single sequencer with its group,
// chip and word counters then walks the words and emits one per cycle
// while the output register is free or drained, so output stalls hold it.
// in_ready is low while a command is being walked; the output register lets
// the last word wait while the next item is taken. Configuration writes are
// always ready and land at once; an init uses the settings as each of its
// words is built.
module led_matrix_cascade_refresh #(
  parameter int CHAIN_LENGTH = 4,
  parameter int DIGIT_COUNT  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lmcr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lmcr_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [lmcr_pkg::CHIP_W-1:0] CHIP_LAST =
    lmcr_pkg::CHIP_W'(CHAIN_LENGTH - 1);
  localparam logic [lmcr_pkg::GRP_W-1:0] DIGIT_LAST =
    lmcr_pkg::GRP_W'(DIGIT_COUNT - 1);
  localparam logic [6:0] FRAME_LIMIT = 7'(CHAIN_LENGTH * 8);

  // Configuration registers
  logic [3:0] intensity_level;
  logic [2:0] scan_limit;
  logic [7:0] decode_mode;

  // Frame store: one segment byte per chip and digit
  logic [7:0] frame_store [lmcr_pkg::FRAME_DEPTH];

  // Sequencer
  logic                              state;
  logic                              refresh_mode;
  logic [lmcr_pkg::GRP_W-1:0]        grp;
  logic [lmcr_pkg::CHIP_W-1:0]       chip;
  logic [lmcr_pkg::COUNT_W-1:0]      count;

  logic                              in_fire;
  logic                              emit;
  logic                              chip_last;
  logic                              grp_last;
  logic                              word_last;
  logic [7:0]                        word_addr;
  logic [7:0]                        word_byte;
  logic [7:0]                        frame_byte;
  lmcr_pkg::out_item_t               word_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  // Load a word whenever the output register is free or being drained
  assign emit      = (state == ST_RUN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_level <= 4'd15;
      scan_limit      <= 3'd7;
      decode_mode     <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lmcr_pkg::CFG_INTENSITY: intensity_level <= cfg_data[3:0];
        lmcr_pkg::CFG_SCAN:      scan_limit      <= cfg_data[2:0];
        lmcr_pkg::CFG_DECODE:    decode_mode     <= cfg_data;
        default: ;               // drop writes beyond the register list
      endcase
    end
  end

  // Store frame bytes; positions beyond the chain are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lmcr_pkg::FRAME_DEPTH; i++) begin
        frame_store[i] <= 8'd0;
      end
    end else if (in_fire && in_data.opcode == lmcr_pkg::OP_WRITE &&
                 {2'b00, in_data.byte_index} < FRAME_LIMIT) begin
      frame_store[in_data.byte_index] <= in_data.byte_value;
    end
  end

  // Frame position chip*8 + digit lies in the store only for chips 0 to 3
  always_comb begin
    if (chip[2] == 1'b0) begin
      frame_byte = frame_store[{chip[1:0], grp}];
    end else begin
      frame_byte = 8'd0;
    end
  end

  // Shared word builder: address and data of the current group and chip
  always_comb begin
    if (refresh_mode) begin
      word_addr = 8'(grp) + 8'd1;
      word_byte = frame_byte;
    end else begin
      word_addr = lmcr_pkg::init_addr(grp);
      case (grp)
        lmcr_pkg::GRP_DECODE:    word_byte = decode_mode;
        lmcr_pkg::GRP_INTENSITY: word_byte = {4'd0, intensity_level};
        lmcr_pkg::GRP_SCAN:      word_byte = {5'd0, scan_limit};
        lmcr_pkg::GRP_TEST:      word_byte = lmcr_pkg::TEST_OFF_DATA;
        default:                 word_byte = lmcr_pkg::NORMAL_OP_DATA;
      endcase
    end
  end

  assign chip_last = (chip == CHIP_LAST);
  assign grp_last  = refresh_mode ? (grp == DIGIT_LAST) : (grp == lmcr_pkg::INIT_LAST_GRP);
  // End at the natural last word or at the 32-word cap
  assign word_last = (chip_last && grp_last) || (count == lmcr_pkg::MAX_WORD_IDX);

  always_comb begin
    word_next.word_out    = {word_addr, word_byte};
    word_next.chain_slot  = chip[1:0];
    word_next.latch_after = chip_last;
    word_next.last_word   = word_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      refresh_mode <= 1'b0;
      grp          <= '0;
      chip         <= '0;
      count        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire && (in_data.opcode == lmcr_pkg::OP_INIT ||
                          in_data.opcode == lmcr_pkg::OP_REFRESH)) begin
            state        <= ST_RUN;
            refresh_mode <= (in_data.opcode == lmcr_pkg::OP_REFRESH);
            grp          <= '0;
            chip         <= '0;
            count        <= '0;
          end
        end
        ST_RUN: begin
          if (emit) begin
            count <= count + 1'b1;
            if (word_last) begin
              state <= ST_IDLE;
            end else if (chip_last) begin
              chip <= '0;
              grp  <= grp + 1'b1;
            end else begin
              chip <= chip + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= word_next;
    end
  end

endmodule

### design/lmcr_checker.sv
// Port-level checker of the cascaded LED matrix refresh driver, with its bind.
`include "led_matrix_cascade_refresh_macros.svh"

module lmcr_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input lmcr_pkg::in_item_t   in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input lmcr_pkg::out_item_t  out_data
);

  // A stalled word holds
  `LMCR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_data), "stalled word changed or dropped")

  // While more words of a command are due, no new item is taken
  `LMCR_ASSERT_NOW(a_busy_no_accept, clk, rst, out_valid && !out_data.last_word,
    !in_ready, "item taken before command finished")

  // A frame write on an empty output gives no word
  `LMCR_ASSERT_NEXT(a_write_silent, clk, rst,
    in_valid && in_ready && !out_valid && in_data.opcode == lmcr_pkg::OP_WRITE,
    !out_valid, "frame write produced a word")

  // Reset leaves the block ready and the output empty
  `LMCR_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst,
    in_ready && !out_valid, "block not idle after reset")

endmodule

bind led_matrix_cascade_refresh lmcr_checker u_lmcr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### bench/led_matrix_cascade_refresh_test.sv
// Self-checking testbench of the cascaded LED matrix refresh driver.
`timescale 1ns / 1ps

module led_matrix_cascade_refresh_test;

  localparam int CHAIN_LENGTH = 4;
  localparam int DIGIT_COUNT  = 8;
  localparam int WORD_CAP     = 32;   // most words one command may give
  localparam int INIT_GROUPS  = 5;

  // Opcode 3 has no name in the package; the block drops it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 40;
  localparam int HOLD_OFF_CYCLES = 400;  // long output stall to back up the input
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 22;

  typedef struct {
    bit                 is_cfg;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_value;
    lmcr_pkg::in_item_t cmd;
    bit                 has_lit;    // first word typed in by hand
    logic [15:0]        lit_word;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lmcr_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lmcr_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = lmcr_pkg::CFG_INTENSITY;
  logic [7:0]          cfg_data = '0;

  // Shadow of the block: frame bytes and the three settings.
  logic [7:0] frame_shadow [lmcr_pkg::FRAME_DEPTH];
  logic [3:0] intensity_shadow = 4'd15;
  logic [2:0] scan_shadow      = 3'd7;
  logic [7:0] decode_shadow    = 8'd0;

  lmcr_pkg::out_item_t expected_words [$];

  int  mismatch_count = 0;
  int  words_checked  = 0;
  int  commands_taken = 0;
  int  reg_writes     = 0;
  bit  no_idle        = 1'b0;  // stretch with no gaps on either side
  bit  hold_off_req   = 1'b0;  // ask the receiver for a long stall
  int  stall_left     = 0;

  script_row_t script [23];

  led_matrix_cascade_refresh #(
    .CHAIN_LENGTH(CHAIN_LENGTH),
    .DIGIT_COUNT (DIGIT_COUNT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    foreach (frame_shadow[i]) frame_shadow[i] = 8'h00;
  end

  // Mostly short gaps, now and then a long one; none in a no-idle stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic void push_word(ref lmcr_pkg::out_item_t words[$],
                                    input logic [7:0] addr,
                                    input logic [7:0] data, input int chip);
    lmcr_pkg::out_item_t w;
    if (words.size() >= WORD_CAP) return;
    w.word_out    = {addr, data};
    w.chain_slot  = 2'(chip);
    w.latch_after = (chip == CHAIN_LENGTH - 1);
    w.last_word   = 1'b0;
    words.push_back(w);
  endfunction

  // Work out the words one command gives and update the shadow state.
  function automatic void predict_words(input lmcr_pkg::in_item_t cmd,
                                        ref lmcr_pkg::out_item_t words[$]);
    logic [7:0] grp_reg [INIT_GROUPS];
    logic [7:0] grp_val [INIT_GROUPS];
    int pos;
    words.delete();
    grp_reg = '{lmcr_pkg::REG_DECODE, lmcr_pkg::REG_INTENSITY, lmcr_pkg::REG_SCAN,
                lmcr_pkg::REG_TEST, lmcr_pkg::REG_SHUTDOWN};
    grp_val = '{decode_shadow, {4'd0, intensity_shadow}, {5'd0, scan_shadow},
                lmcr_pkg::TEST_OFF_DATA, lmcr_pkg::NORMAL_OP_DATA};
    case (cmd.opcode)
      lmcr_pkg::OP_WRITE: begin
        // drop writes beyond the end of the chain
        if (int'(cmd.byte_index) < CHAIN_LENGTH * 8)
          frame_shadow[cmd.byte_index] = cmd.byte_value;
      end
      lmcr_pkg::OP_INIT: begin
        for (int g = 0; g < INIT_GROUPS; g++)
          for (int chip = 0; chip < CHAIN_LENGTH; chip++)
            push_word(words, grp_reg[g], grp_val[g], chip);
      end
      lmcr_pkg::OP_REFRESH: begin
        for (int d = 0; d < DIGIT_COUNT; d++)
          for (int chip = 0; chip < CHAIN_LENGTH; chip++) begin
            pos = chip * 8 + d;
            push_word(words, 8'(d + 1),
                      (pos < lmcr_pkg::FRAME_DEPTH) ? frame_shadow[pos] : 8'h00, chip);
          end
      end
      default: ;
    endcase
    if (words.size() > 0) words[words.size() - 1].last_word = 1'b1;
  endfunction

  function automatic void check_word(input lmcr_pkg::out_item_t got);
    lmcr_pkg::out_item_t want;
    if (expected_words.size() == 0) begin
      $error("word_out expected none actual %h", got.word_out);
      mismatch_count++;
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (got.word_out !== want.word_out) begin
      $error("word_out expected %h actual %h", want.word_out, got.word_out);
      mismatch_count++;
    end
    if (got.chain_slot !== want.chain_slot) begin
      $error("chain_slot expected %0d actual %0d", want.chain_slot, got.chain_slot);
      mismatch_count++;
    end
    if (got.latch_after !== want.latch_after) begin
      $error("latch_after expected %0d actual %0d", want.latch_after, got.latch_after);
      mismatch_count++;
    end
    if (got.last_word !== want.last_word) begin
      $error("last_word expected %0d actual %0d", want.last_word, got.last_word);
      mismatch_count++;
    end
  endfunction

  function automatic script_row_t cmd_row(input logic [1:0] op, input logic [4:0] idx,
                                          input logic [7:0] val, input bit has_lit,
                                          input logic [15:0] lit);
    script_row_t row;
    row.is_cfg    = 1'b0;
    row.cfg_index = lmcr_pkg::CFG_INTENSITY;
    row.cfg_value = 8'h00;
    row.cmd       = '{opcode: op, byte_index: idx, byte_value: val};
    row.has_lit   = has_lit;
    row.lit_word  = lit;
    return row;
  endfunction

  function automatic script_row_t cfg_row(input logic [1:0] idx, input logic [7:0] val);
    script_row_t row;
    row           = cmd_row(lmcr_pkg::OP_WRITE, 5'd0, 8'h00, 1'b0, 16'h0000);
    row.is_cfg    = 1'b1;
    row.cfg_index = idx;
    row.cfg_value = val;
    return row;
  endfunction

  function automatic lmcr_pkg::in_item_t random_command();
    lmcr_pkg::in_item_t c;
    int r;
    r = $urandom_range(0, 99);
    c.opcode = (r < 55) ? lmcr_pkg::OP_WRITE : (r < 80) ? lmcr_pkg::OP_REFRESH :
               (r < 92) ? lmcr_pkg::OP_INIT : OP_UNUSED;
    c.byte_index = 5'($urandom_range(0, 31));
    r = $urandom_range(0, 9);
    c.byte_value = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Offer one item, hold it until taken, then queue the words it causes.
  // Valid stays high on return so a back-to-back item needs no toggle.
  task automatic send_command(input lmcr_pkg::in_item_t cmd, input bit has_lit,
                              input logic [15:0] lit);
    lmcr_pkg::out_item_t words [$];
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    predict_words(cmd, words);
    // a hand-typed first word replaces the predicted one
    if (has_lit && words.size() > 0) words[0].word_out = lit;
    foreach (words[i]) expected_words.push_back(words[i]);
    commands_taken++;
  endtask

  // Drop valid, wait out every expected word, then let a write finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the task drops cfg_valid and steps past the write before returning.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lmcr_pkg::CFG_INTENSITY: intensity_shadow = val[3:0];
      lmcr_pkg::CFG_SCAN:      scan_shadow      = val[2:0];
      lmcr_pkg::CFG_DECODE:    decode_shadow    = val;
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: check every word taken, then maybe stall before the next.
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        check_word(out_data);
        if (stall_left == 0) stall_left = pick_gap();
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sender: reset, directed script, then random phases with fresh settings.
  initial begin
    lmcr_pkg::in_item_t cmd;
    int counted;
    logic [3:0] new_intensity;
    logic [2:0] new_scan;
    logic [7:0] new_decode;

    script = '{
      // reset state: blank frame, default settings
      cmd_row(lmcr_pkg::OP_REFRESH, 5'd0,  8'h00, 1'b1, 16'h0100),
      cmd_row(lmcr_pkg::OP_INIT,    5'd0,  8'h00, 1'b1, 16'h0900),
      // fill the frame corners and a few inner bytes
      cmd_row(lmcr_pkg::OP_WRITE,   5'd0,  8'hFF, 1'b0, 16'h0000),
      cmd_row(lmcr_pkg::OP_WRITE,   5'd31, 8'h80, 1'b0, 16'h0000),
      cmd_row(lmcr_pkg::OP_WRITE,   5'd7,  8'h01, 1'b0, 16'h0000),
      cmd_row(lmcr_pkg::OP_WRITE,   5'd24, 8'h55, 1'b0, 16'h0000),
      cmd_row(lmcr_pkg::OP_WRITE,   5'd13, 8'hA5, 1'b0, 16'h0000),
      // unused opcode must leave the frame alone
      cmd_row(OP_UNUSED,            5'd5,  8'hAA, 1'b0, 16'h0000),
      cmd_row(lmcr_pkg::OP_REFRESH, 5'd0,  8'h00, 1'b1, 16'h01FF),
      // low extremes of the settings, all-ones decode
      cfg_row(lmcr_pkg::CFG_INTENSITY, 8'h00),
      cfg_row(lmcr_pkg::CFG_SCAN,      8'h00),
      cfg_row(lmcr_pkg::CFG_DECODE,    8'hFF),
      cmd_row(lmcr_pkg::OP_INIT,    5'd0,  8'h00, 1'b1, 16'h09FF),
      cmd_row(OP_UNUSED,            5'd31, 8'hFF, 1'b0, 16'h0000),
      cmd_row(lmcr_pkg::OP_WRITE,   5'd0,  8'h00, 1'b0, 16'h0000),
      // high extremes back, raw segments
      cfg_row(lmcr_pkg::CFG_INTENSITY, 8'h0F),
      cfg_row(lmcr_pkg::CFG_SCAN,      8'h07),
      cfg_row(lmcr_pkg::CFG_DECODE,    8'h00),
      cmd_row(lmcr_pkg::OP_INIT,    5'd0,  8'h00, 1'b1, 16'h0900),
      cmd_row(lmcr_pkg::OP_REFRESH, 5'd31, 8'hFF, 1'b0, 16'h0000),
      cmd_row(lmcr_pkg::OP_WRITE,   5'd16, 8'h5A, 1'b0, 16'h0000),
      cmd_row(lmcr_pkg::OP_REFRESH, 5'd0,  8'h00, 1'b0, 16'h0000),
      cmd_row(lmcr_pkg::OP_INIT,    5'd31, 8'hFF, 1'b0, 16'h0000)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        write_reg(script[i].cfg_index, script[i].cfg_value);
      end else begin
        send_command(script[i].cmd, script[i].has_lit, script[i].lit_word);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      // drain before touching the settings
      settle();
      if (p == 1) begin
        new_intensity = 4'd15;
        new_scan      = 3'd0;
        new_decode    = 8'hFF;
      end else begin
        new_intensity = 4'($urandom_range(0, 15));
        new_scan      = 3'($urandom_range(0, 7));
        new_decode    = 8'($urandom_range(0, 255));
      end
      write_reg(lmcr_pkg::CFG_INTENSITY, {4'd0, new_intensity});
      write_reg(lmcr_pkg::CFG_SCAN,      {5'd0, new_scan});
      write_reg(lmcr_pkg::CFG_DECODE,    new_decode);
      no_idle = (p == 2);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        // stall the output for a long stretch while items keep coming
        if (p == 3 && counted == 3) hold_off_req = 1'b1;
        cmd = random_command();
        send_command(cmd, 1'b0, 16'h0000);
        if (cmd.opcode != OP_UNUSED) counted++;
      end
    end
    no_idle = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("word_out expected %0d more words, actual none", expected_words.size());
      mismatch_count++;
    end

    $display("Ran %0d commands with %0d register writes over %0d setting phases;",
             commands_taken, reg_writes, PHASES + 3);
    $display("checked %0d words, with random gaps and one long output stall.",
             words_checked);
    if (mismatch_count == 0) begin
      $display("[led_matrix_cascade_refresh] OK");
    end else begin
      $display("[led_matrix_cascade_refresh] ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest run the stalls allow.
  initial begin
    #20_000_000;
    $display("[led_matrix_cascade_refresh] ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/lmcr_pkg.sv
design/led_matrix_cascade_refresh.sv
design/lmcr_checker.sv
bench/led_matrix_cascade_refresh_test.sv
